// ----- rtl/core/rsht_pkg.sv -----
package rsht_pkg;

  localparam int MaxSegments = 256;
  localparam int IdxW        = $clog2(MaxSegments);
  localparam int CntW        = IdxW + 1;
  localparam int CoordW      = 16;
  localparam int EntryW      = 4 * CoordW;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic            load_rect;
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            stage_en;
  } dp_cmd_t;

  // Datapath to controller: result of the segment whose test has just finished.
  typedef struct packed {
    logic hit;
  } dp_sts_t;

  // Input word.
  typedef struct packed {
    logic                     opcode;
    logic [7:0]               entry_index;
    logic signed [CoordW-1:0] seg_begin_x;
    logic signed [CoordW-1:0] seg_begin_y;
    logic signed [CoordW-1:0] seg_end_x;
    logic signed [CoordW-1:0] seg_end_y;
    logic signed [CoordW-1:0] rect_left;
    logic signed [CoordW-1:0] rect_top;
    logic signed [CoordW-1:0] rect_right;
    logic signed [CoordW-1:0] rect_bottom;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic            hit_found;
    logic [CntW-1:0] hit_number;
  } out_word_t;

endpackage

// ----- rtl/core/rsht_if.sv -----
interface rsht_in_if;
  logic               valid;
  logic               ready;
  rsht_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rsht_out_if;
  logic                valid;
  logic                ready;
  rsht_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/rect_segment_hit_test_core.sv -----
// Operation: a load writes its table entry when accepted; a query scans segments
// 0 to segment_count-1 through the read register, the product stage and the hit
// register, and stops at the first hit (it goes straight to the result when the count is zero).
// Throughput: one query at a time; the scan reads one table entry per cycle
// from the single read port and tests all four rectangle edges in parallel.
// Reset: asynchronous, active low; clears control state and segment_count. The
// segment table is not cleared and holds garbage until written.
module rect_segment_hit_test_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [rsht_pkg::CntW-1:0] cfg_wdata_i,
  rsht_in_if.sink                   in_if,
  rsht_out_if.source                out_if
);

  logic [rsht_pkg::CntW-1:0] count_q;

  // Segment count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  rsht_pkg::dp_cmd_t cmd;
  rsht_pkg::dp_sts_t sts;
  logic              in_ready;
  logic              wr_en;

  assign in_if.ready = in_ready;
  assign wr_en = in_if.valid && in_ready && (in_if.data.opcode == rsht_pkg::OP_LOAD);

  rsht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_opcode_i (in_if.data.opcode),
    .in_ready_o  (in_ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_o  (out_if.data),
    .count_i     (count_q),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rsht_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .wr_en_i       (wr_en),
    .wr_addr_i     (in_if.data.entry_index[rsht_pkg::IdxW-1:0]),
    .wr_data_i     ({in_if.data.seg_end_y, in_if.data.seg_end_x,
                     in_if.data.seg_begin_y, in_if.data.seg_begin_x}),
    .rect_left_i   (in_if.data.rect_left),
    .rect_top_i    (in_if.data.rect_top),
    .rect_right_i  (in_if.data.rect_right),
    .rect_bottom_i (in_if.data.rect_bottom),
    .sts_o         (sts)
  );

endmodule

// ----- rtl/core/rsht_datapath.sv -----
module rsht_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  rsht_pkg::dp_cmd_t                     cmd_i,
  input  logic                                  wr_en_i,
  input  logic [rsht_pkg::IdxW-1:0]             wr_addr_i,
  input  logic [rsht_pkg::EntryW-1:0]           wr_data_i,
  input  logic signed [rsht_pkg::CoordW-1:0]    rect_left_i,
  input  logic signed [rsht_pkg::CoordW-1:0]    rect_top_i,
  input  logic signed [rsht_pkg::CoordW-1:0]    rect_right_i,
  input  logic signed [rsht_pkg::CoordW-1:0]    rect_bottom_i,
  output rsht_pkg::dp_sts_t                     sts_o
);

  localparam int W  = rsht_pkg::CoordW;
  localparam int DW = W + 1;      // coordinate differences
  localparam int PW = 2 * DW;     // one product
  localparam int SW = PW + 1;     // difference of two products

  // Segment table memory with registered read.
  logic [rsht_pkg::EntryW-1:0] mem_q [rsht_pkg::MaxSegments];
  logic [rsht_pkg::EntryW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[cmd_i.rd_addr];
    end
  end

  // Rectangle held for the whole scan.
  logic signed [W-1:0] l_q, t_q, r_q, b_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rect) begin
      l_q <= rect_left_i;
      t_q <= rect_top_i;
      r_q <= rect_right_i;
      b_q <= rect_bottom_i;
    end
  end

  logic signed [W-1:0] px, py, ex, ey;
  assign px = rd_q[W-1:0];
  assign py = rd_q[2*W-1:W];
  assign ex = rd_q[3*W-1:2*W];
  assign ey = rd_q[4*W-1:3*W];

  // Edge endpoints: top, bottom, left, right.
  logic signed [W-1:0] ax [4], ay [4], bx [4], by [4];
  always_comb begin
    ax[0] = l_q; ay[0] = t_q; bx[0] = r_q; by[0] = t_q;
    ax[1] = l_q; ay[1] = b_q; bx[1] = r_q; by[1] = b_q;
    ax[2] = l_q; ay[2] = t_q; bx[2] = l_q; by[2] = b_q;
    ax[3] = r_q; ay[3] = t_q; bx[3] = r_q; by[3] = b_q;
  end

  // Stage one: products of each edge test, registered.
  logic signed [PW-1:0] m_q [4][6];
  logic                 s1_vld_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      logic signed [DW-1:0] sdx, sdy, edx, edy, ox, oy;
      sdx = DW'(ex) - DW'(px);
      sdy = DW'(ey) - DW'(py);
      edx = DW'(bx[k]) - DW'(ax[k]);
      edy = DW'(by[k]) - DW'(ay[k]);
      ox  = DW'(px) - DW'(ax[k]);
      oy  = DW'(py) - DW'(ay[k]);
      if (cmd_i.stage_en) begin
        m_q[k][0] <= sdx * edy;
        m_q[k][1] <= sdy * edx;
        m_q[k][2] <= oy * edx;
        m_q[k][3] <= ox * edy;
        m_q[k][4] <= oy * sdx;
        m_q[k][5] <= ox * sdy;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.stage_en;
    end
  end

  // Stage two: differences and range compares, one hit bit registered.
  logic hit_q;

  always_ff @(posedge clk_i) begin
    logic any;
    any = 1'b0;
    for (int k = 0; k < 4; k++) begin
      logic signed [SW-1:0] d, q1, q2;
      logic ok1, ok2;
      d  = SW'(m_q[k][0]) - SW'(m_q[k][1]);
      q1 = SW'(m_q[k][2]) - SW'(m_q[k][3]);
      q2 = SW'(m_q[k][4]) - SW'(m_q[k][5]);
      if (d > 0) begin
        ok1 = (q1 >= 0) && (q1 <= d);
        ok2 = (q2 >= 0) && (q2 <= d);
      end else begin
        ok1 = (q1 <= 0) && (q1 >= d);
        ok2 = (q2 <= 0) && (q2 >= d);
      end
      any = any | ((d != 0) && ok1 && ok2);
    end
    if (s1_vld_q) begin
      hit_q <= any;
    end
  end

  assign sts_o.hit = hit_q;

endmodule

// ----- rtl/core/rsht_ctrl.sv -----
module rsht_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_opcode_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output rsht_pkg::out_word_t       out_data_o,
  input  logic [rsht_pkg::CntW-1:0] count_i,
  output rsht_pkg::dp_cmd_t         cmd_o,
  input  rsht_pkg::dp_sts_t         sts_i
);

  localparam int CW = rsht_pkg::CntW;

  rsht_pkg::state_e state_q, state_d;

  // Issue pointer and number of the segment being checked at the end of the pipe.
  logic [CW-1:0] issue_q, issue_d;
  logic [CW-1:0] chk_q, chk_d;
  logic [CW-1:0] limit_q, limit_d;
  logic [1:0]    fill_q, fill_d;
  rsht_pkg::out_word_t res_q, res_d;

  logic [CW-1:0] limit_in;
  assign limit_in = (count_i > CW'(rsht_pkg::MaxSegments)) ?
                    CW'(rsht_pkg::MaxSegments) : count_i;

  logic take_query;
  assign take_query = in_valid_i && in_ready_o &&
                      (in_opcode_i == rsht_pkg::OP_QUERY);

  // Hit bit of segment chk_q appears when fill reaches three.
  logic result_here;
  assign result_here = (fill_q == 2'd3);

  // Next state.
  always_comb begin
    state_d = state_q;
    issue_d = issue_q;
    chk_d   = chk_q;
    limit_d = limit_q;
    fill_d  = fill_q;
    res_d   = res_q;
    case (state_q)
      rsht_pkg::ST_IDLE: begin
        if (take_query) begin
          limit_d = limit_in;
          issue_d = '0;
          chk_d   = '0;
          fill_d  = '0;
          if (limit_in == '0) begin
            res_d   = '0;
            state_d = rsht_pkg::ST_DONE;
          end else begin
            state_d = rsht_pkg::ST_SCAN;
          end
        end
      end
      rsht_pkg::ST_SCAN, rsht_pkg::ST_PRIME, rsht_pkg::ST_DRAIN: begin
        if (issue_q < limit_q) begin
          issue_d = issue_q + 1'b1;
        end
        if (fill_q != 2'd3) begin
          fill_d = fill_q + 1'b1;
        end
        if (result_here) begin
          chk_d = chk_q + 1'b1;
          if (sts_i.hit) begin
            res_d.hit_found  = 1'b1;
            res_d.hit_number = chk_q + 1'b1;
            state_d = rsht_pkg::ST_DONE;
          end else if (chk_q + 1'b1 == limit_q) begin
            res_d   = '0;
            state_d = rsht_pkg::ST_DONE;
          end
        end
      end
      rsht_pkg::ST_DONE: begin
        if (out_ready_i) begin
          state_d = rsht_pkg::ST_IDLE;
        end
      end
      default: state_d = rsht_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath commands. The pipe runs freely; extra reads past the
  // limit are harmless since their results are never consumed.
  always_comb begin
    in_ready_o        = (state_q == rsht_pkg::ST_IDLE);
    out_valid_o       = (state_q == rsht_pkg::ST_DONE);
    out_data_o        = res_q;
    cmd_o.load_rect   = take_query;
    cmd_o.rd_en       = (state_q == rsht_pkg::ST_SCAN);
    cmd_o.rd_addr     = issue_q[CW-2:0];
    cmd_o.stage_en    = (state_q == rsht_pkg::ST_SCAN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rsht_pkg::ST_IDLE;
      issue_q <= '0;
      chk_q   <= '0;
      limit_q <= '0;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
      chk_q   <= chk_d;
      limit_q <= limit_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // A result is never shown with a number past the limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (res_q.hit_number <= limit_q))
    else $error("hit number beyond segment count");

  // A found flag always comes with a nonzero number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (res_q.hit_found == (res_q.hit_number != '0)))
    else $error("hit flag and number disagree");

  // The checked segment never runs ahead of the issued one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rsht_pkg::ST_SCAN) |-> (chk_q <= issue_q))
    else $error("check pointer ahead of issue pointer");

endmodule

// ----- sim/tb_rect_segment_hit_test_core.sv -----
module tb_rect_segment_hit_test_core;

  localparam int CycleLimit = 2000000;
  localparam int NumItems   = 900;
  localparam int InW        = $bits(rsht_pkg::in_word_t);

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [rsht_pkg::CntW-1:0] cfg_wdata_i;

  rsht_in_if  in_if ();
  rsht_out_if out_if ();

  rect_segment_hit_test_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if.sink),
    .out_if     (out_if.source)
  );

  // Predictor state: its own copy of the table and the count.
  logic [rsht_pkg::EntryW-1:0] seg_store [rsht_pkg::MaxSegments];
  logic [rsht_pkg::CntW-1:0]   scan_count;
  rsht_pkg::out_word_t         hit_queue [$];
  int                          err_count;
  int                          cycle_count = 0;
  int                          items_sent  = 0;

  always #1 clk_i = ~clk_i;

  // Count cycles and stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_rect_segment_hit_test_core: done, errors");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    err_count++;
  endtask

  function automatic bit in_span(longint q, longint d);
    if (d > 0) return q >= 0 && q <= d;
    return q <= 0 && q >= d;
  endfunction

  // Exact parametric test of segment p->e against edge a->b.
  function automatic bit edge_cross(longint px, longint py, longint ex, longint ey,
                                    longint ax, longint ay, longint bx, longint by);
    longint sdx, sdy, edx, edy, ox, oy, d;
    sdx = ex - px; sdy = ey - py;
    edx = bx - ax; edy = by - ay;
    ox = px - ax;  oy = py - ay;
    d = sdx * edy - sdy * edx;
    if (d == 0) return 0;
    return in_span(oy * edx - ox * edy, d) && in_span(oy * sdx - ox * sdy, d);
  endfunction

  function automatic rsht_pkg::out_word_t first_hit(rsht_pkg::in_word_t w);
    rsht_pkg::out_word_t r;
    int n;
    longint px, py, ex, ey, l, t, rt, b;
    l = w.rect_left; t = w.rect_top; rt = w.rect_right; b = w.rect_bottom;
    n = (scan_count > rsht_pkg::MaxSegments) ? rsht_pkg::MaxSegments : scan_count;
    r = '0;
    for (int i = 0; i < n; i++) begin
      px = $signed(seg_store[i][15:0]);  py = $signed(seg_store[i][31:16]);
      ex = $signed(seg_store[i][47:32]); ey = $signed(seg_store[i][63:48]);
      if (edge_cross(px, py, ex, ey, l, t, rt, t) ||
          edge_cross(px, py, ex, ey, l, b, rt, b) ||
          edge_cross(px, py, ex, ey, l, t, l, b) ||
          edge_cross(px, py, ex, ey, rt, t, rt, b)) begin
        r.hit_found  = 1'b1;
        r.hit_number = rsht_pkg::CntW'(i + 1);
        return r;
      end
    end
    return r;
  endfunction

  // Update the predictor with one accepted word.
  function automatic void absorb_word(rsht_pkg::in_word_t w);
    if (w.opcode == rsht_pkg::OP_LOAD) begin
      seg_store[w.entry_index] = {w.seg_end_y, w.seg_end_x, w.seg_begin_y, w.seg_begin_x};
    end else begin
      hit_queue.insert(hit_queue.size(), first_hit(w));
    end
  endfunction

  // Gap length: mostly zero or short, sometimes long.
  function automatic int gap_len();
    int k;
    k = $urandom_range(99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Sink side: random ready with a long stall now and then; check each
  // accepted result word.
  initial begin
    int                  stall_left;
    int                  until_stall;
    rsht_pkg::out_word_t e;
    out_if.ready = 1'b0;
    stall_left   = 0;
    until_stall  = $urandom_range(200, 20);
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        if (hit_queue.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          e = hit_queue.pop_front();
          if (out_if.data.hit_found !== e.hit_found)
            report($sformatf("hit_found %0b exp %0b", out_if.data.hit_found, e.hit_found));
          if (out_if.data.hit_number !== e.hit_number)
            report($sformatf("hit_number %0d exp %0d", out_if.data.hit_number,
                             e.hit_number));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (until_stall == 0) begin
        until_stall  = $urandom_range(200, 20);
        stall_left   = ($urandom_range(3) == 0) ? $urandom_range(30, 5) : 0;
        out_if.ready <= 1'b0;
      end else begin
        until_stall--;
        out_if.ready <= ($urandom_range(3) != 0);
      end
    end
  end

  // Send one word and wait for its acceptance; gap before it.
  task automatic send_word(rsht_pkg::in_word_t w);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_if.valid <= 1'b0;
      in_if.data  <= rsht_pkg::in_word_t'(InW'({$urandom, $urandom, $urandom,
                                                $urandom, $urandom}));
      repeat (g) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk_i); while (!in_if.ready);
    absorb_word(w);
    items_sent++;
  endtask

  task automatic drop_valid();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for every expected result, then a tail, then write the count.
  task automatic write_count(logic [rsht_pkg::CntW-1:0] v);
    drop_valid();
    while (hit_queue.size() != 0) @(posedge clk_i);
    repeat (rsht_pkg::MaxSegments + 10) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    scan_count = v;
  endtask

  function automatic logic signed [rsht_pkg::CoordW-1:0] rnd_coord();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2, 3: return rsht_pkg::CoordW'($urandom);
      default: return rsht_pkg::CoordW'($signed($urandom_range(400)) - 200);
    endcase
  endfunction

  function automatic rsht_pkg::in_word_t make_load(int idx);
    rsht_pkg::in_word_t w;
    w = rsht_pkg::in_word_t'(InW'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    w.opcode      = rsht_pkg::OP_LOAD;
    w.entry_index = 8'(idx);
    w.seg_begin_x = rnd_coord(); w.seg_begin_y = rnd_coord();
    w.seg_end_x   = rnd_coord(); w.seg_end_y   = rnd_coord();
    return w;
  endfunction

  function automatic rsht_pkg::in_word_t make_query();
    rsht_pkg::in_word_t w;
    w = rsht_pkg::in_word_t'(InW'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    w.opcode     = rsht_pkg::OP_QUERY;
    w.rect_left  = rnd_coord(); w.rect_top    = rnd_coord();
    w.rect_right = rnd_coord(); w.rect_bottom = rnd_coord();
    return w;
  endfunction

  // Directed stimulus: opcode, index, segment, rectangle, typed expectation
  // where it is plain (check_it), else the predictor decides.
  typedef struct {
    logic                               op;
    int                                 idx;
    logic signed [rsht_pkg::CoordW-1:0] c [8];
    bit                                 check_it;
    rsht_pkg::out_word_t                want;
  } stim_row_t;

  stim_row_t stim_rows [$];

  function automatic stim_row_t row(logic op, int idx,
                                    int a, int b, int c, int d,
                                    int l, int t, int r, int bt,
                                    bit chk, bit hf, int hn);
    stim_row_t s;
    s.op = op; s.idx = idx;
    s.c[0] = rsht_pkg::CoordW'(a); s.c[1] = rsht_pkg::CoordW'(b);
    s.c[2] = rsht_pkg::CoordW'(c); s.c[3] = rsht_pkg::CoordW'(d);
    s.c[4] = rsht_pkg::CoordW'(l); s.c[5] = rsht_pkg::CoordW'(t);
    s.c[6] = rsht_pkg::CoordW'(r); s.c[7] = rsht_pkg::CoordW'(bt);
    s.check_it = chk;
    s.want.hit_found = hf;
    s.want.hit_number = rsht_pkg::CntW'(hn);
    return s;
  endfunction

  function automatic void add_row(stim_row_t s);
    stim_rows.insert(stim_rows.size(), s);
  endfunction

  initial begin
    rsht_pkg::in_word_t w;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    err_count = 0;
    scan_count = '0;
    foreach (seg_store[i]) seg_store[i] = '0;

    // Query with count 0 after reset, then loads and the special cases.
    add_row(row(rsht_pkg::OP_QUERY, 0, 0,0,0,0, -100,-100,100,100, 1, 0, 0));
    add_row(row(rsht_pkg::OP_LOAD, 0, -200,0,200,0, 0,0,0,0, 0, 0, 0));
    add_row(row(rsht_pkg::OP_LOAD, 1, 0,-200,0,200, 0,0,0,0, 0, 0, 0));
    add_row(row(rsht_pkg::OP_LOAD, 2, 5,5,5,5, 0,0,0,0, 0, 0, 0));
    add_row(row(rsht_pkg::OP_LOAD, 3, -32768,-32768,32767,32767, 0,0,0,0, 0, 0, 0));
    add_row(row(rsht_pkg::OP_LOAD, 255, 32767,-32768,-32768,32767, 0,0,0,0, 0, 0, 0));
    for (int i = 4; i < 255; i++)
      add_row(row(rsht_pkg::OP_LOAD, i, 1000,1000,1000,1000, 0,0,0,0, 0, 0, 0));
    write_count(9'd0);

    // Drive the rows with the count still 0.
    foreach (stim_rows[k]) begin
      w = '0;
      w.opcode = stim_rows[k].op;
      w.entry_index = 8'(stim_rows[k].idx);
      {w.seg_begin_x, w.seg_begin_y, w.seg_end_x, w.seg_end_y} =
        {stim_rows[k].c[0], stim_rows[k].c[1], stim_rows[k].c[2], stim_rows[k].c[3]};
      {w.rect_left, w.rect_top, w.rect_right, w.rect_bottom} =
        {stim_rows[k].c[4], stim_rows[k].c[5], stim_rows[k].c[6], stim_rows[k].c[7]};
      send_word(w);
      if (stim_rows[k].check_it && hit_queue.size() != 0 &&
          hit_queue[$] != stim_rows[k].want)
        report($sformatf("predictor disagrees on directed row %0d", k));
    end
    stim_rows.delete();

    // Full table: crossings, parallel, collinear, degenerate, extremes.
    write_count(9'd256);
    add_row(row(rsht_pkg::OP_QUERY, 0, 0,0,0,0, -100,-100,100,100, 1, 1, 1));
    add_row(row(rsht_pkg::OP_QUERY, 0, 0,0,0,0, -300,50,300,60, 1, 1, 2));
    add_row(row(rsht_pkg::OP_QUERY, 0, 0,0,0,0, -300,0,300,0, 0, 0, 0));
    add_row(row(rsht_pkg::OP_QUERY, 0, 0,0,0,0, 5,5,5,5, 0, 0, 0));
    add_row(row(rsht_pkg::OP_QUERY, 0, 0,0,0,0, -32768,-32768,32767,32767, 0, 0, 0));
    add_row(row(rsht_pkg::OP_QUERY, 0, 0,0,0,0, 32767,32767,-32768,-32768, 0, 0, 0));
    add_row(row(rsht_pkg::OP_QUERY, 0, 0,0,0,0, 400,400,500,500, 0, 0, 0));
    add_row(row(rsht_pkg::OP_QUERY, 0, 0,0,0,0, 990,990,1010,1010, 0, 0, 0));
    foreach (stim_rows[k]) begin
      w = make_query();
      {w.rect_left, w.rect_top, w.rect_right, w.rect_bottom} =
        {stim_rows[k].c[4], stim_rows[k].c[5], stim_rows[k].c[6], stim_rows[k].c[7]};
      send_word(w);
      if (stim_rows[k].check_it && hit_queue[$] != stim_rows[k].want)
        report($sformatf("predictor disagrees on query row %0d", k));
    end
    write_count(9'd511);
    send_word(make_query());
    write_count(9'd1);
    send_word(make_query());

    // Random phases: mostly loads into the examined range, then queries.
    while (items_sent < NumItems) begin
      int cnt;
      case ($urandom_range(5))
        0: cnt = 256;
        1: cnt = 1;
        2: cnt = 0;
        default: cnt = $urandom_range(24, 2);
      endcase
      write_count(rsht_pkg::CntW'(cnt));
      repeat ($urandom_range(12, 2)) begin
        send_word(make_load(cnt == 0 ? $urandom_range(255) :
                            $urandom_range((cnt > 256 ? 256 : cnt) - 1)));
      end
      repeat ($urandom_range(20, 6)) begin
        if ($urandom_range(9) == 0) send_word(make_load($urandom_range(255)));
        else send_word(make_query());
      end
    end

    drop_valid();
    while (hit_queue.size() != 0) @(posedge clk_i);
    repeat (rsht_pkg::MaxSegments + 20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_rect_segment_hit_test_core: done, clean");
    end else begin
      $display("tb_rect_segment_hit_test_core: done, errors");
    end
    $finish;
  end

  initial begin
    #22 rst_ni = 1'b1;
  end

endmodule
